FILE: sv/qifm_pkg.sv
// qifm_pkg: shared types and constants for the quad in field membership block
// no dependencies
package qifm_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TEST  = 2'd2
  } op_e;

  typedef enum logic {
    BS_IDLE,
    BS_SCAN
  } bstate_e;

  typedef struct packed {
    logic        [1:0]      operation;
    logic signed [ID_W-1:0] star_id;
    logic        [31:0]     quad_index;
    logic signed [ID_W-1:0] quad_star_0;
    logic signed [ID_W-1:0] quad_star_1;
    logic signed [ID_W-1:0] quad_star_2;
    logic signed [ID_W-1:0] quad_star_3;
  } in_t;

  typedef struct packed {
    logic [31:0] result_quad_index;
    logic        all_present;
    logic        overflowed;
  } out_t;

  typedef struct packed {
    logic not_empty;
  } q_ctl_t;

endpackage

FILE: sv/qifm_ram.sv
// qifm_ram: generic single write port ram with registered read
// no dependencies
module qifm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/qifm_front.sv
// qifm_front: accepts commands, drops unused codes, holds them in a short queue
// depends on qifm_pkg
module qifm_front import qifm_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  in_t    item_i,
  output in_t    head_o,
  input  logic   pop_i,
  output logic   not_empty_o
);

  in_t               slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              do_pop;
  logic              op_valid;

  always_comb begin
    op_valid = (item_i.operation == OP_CLEAR) || (item_i.operation == OP_ADD) ||
               (item_i.operation == OP_TEST);
    push     = start && !busy && op_valid;
    do_pop   = pop_i && not_empty_o;
    wptr_d   = wptr_q;
    rptr_d   = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    cnt_d = cnt_q + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  assign busy        = (cnt_q == QCNT_W'(QDEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = slot_q[rptr_q];

endmodule

FILE: sv/qifm_back.sv
// qifm_back: executes queued commands against the field store, scans for tests
// depends on qifm_pkg and qifm_ram
module qifm_back import qifm_pkg::*; #(
  parameter int unsigned MAX_FIELD_STARS = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  in_t    head_i,
  input  q_ctl_t q_i,
  output logic   pop_o,
  output logic   result_valid_o,
  output out_t   result_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_FIELD_STARS);
  localparam int unsigned CNT_W  = $clog2(MAX_FIELD_STARS + 1);

  bstate_e           state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [ADDR_W-1:0] k_q, k_d;
  logic [3:0]        hit_q, hit_d;
  in_t               cur_q, cur_d;
  out_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ID_W-1:0]   rdata;
  logic [3:0]        match;
  logic [3:0]        hit_all;
  logic [CNT_W-1:0]  k_next;

  qifm_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_FIELD_STARS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (head_i.star_id),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    match[0] = (rdata == cur_q.quad_star_0);
    match[1] = (rdata == cur_q.quad_star_1);
    match[2] = (rdata == cur_q.quad_star_2);
    match[3] = (rdata == cur_q.quad_star_3);
    hit_all  = hit_q | match;
    k_next   = CNT_W'(k_q) + CNT_W'(1);

    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    k_d         = k_q;
    hit_d       = hit_q;
    cur_d       = cur_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = count_q[ADDR_W-1:0];
    raddr       = '0;

    case (state_q)
      BS_IDLE: begin
        if (q_i.not_empty) begin
          pop_o = 1'b1;
          case (op_e'(head_i.operation))
            OP_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            OP_ADD: begin
              if (count_q < CNT_W'(MAX_FIELD_STARS)) begin
                we      = 1'b1;
                count_d = count_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_TEST: begin
              cur_d = head_i;
              hit_d = '0;
              k_d   = '0;
              if (count_q == '0) begin
                res_valid_d             = 1'b1;
                res_d.result_quad_index = head_i.quad_index;
                res_d.all_present       = 1'b0;
                res_d.overflowed        = ovf_q;
              end else begin
                state_d = BS_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BS_SCAN: begin
        if (k_next < count_q) begin
          raddr = k_next[ADDR_W-1:0];
          k_d   = k_next[ADDR_W-1:0];
          hit_d = hit_all;
        end else begin
          res_valid_d             = 1'b1;
          res_d.result_quad_index = cur_q.quad_index;
          res_d.all_present       = &hit_all;
          res_d.overflowed        = ovf_q;
          state_d                 = BS_IDLE;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    hit_q <= hit_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: sv/quad_in_field_membership.sv
// quad_in_field_membership: top level, front queue plus field store back end
// depends on qifm_pkg, qifm_front, qifm_back
//
// usage: a command is taken at a rising edge with start high and busy low.
// item_i.operation selects clear (empty the field store, reset the overflow
// flag), add (append item_i.star_id) or test (check the four quad stars).
// code 3 is ignored. clear and add give no result; a test gives one result
// on result_o, marked by result_valid_o for exactly one cycle; the receiver
// cannot stall it.
// commands wait in a two entry queue; busy is high while that queue is full.
// the back end takes one queued command per cycle for clear and add while
// no test is scanning. a test scans the stored ids (at most MAX_FIELD_STARS)
// through the store's single read port, one entry per cycle with four
// comparators; the back end takes no other command during the scan, and the
// test result is registered when the scan ends.
// an add to a full store is dropped and sets the sticky overflow flag,
// reported with each test result.
// reset empties the queue and the store count and clears the flag; the store
// contents are not cleared and are never read before being written.
module quad_in_field_membership import qifm_pkg::*; #(
  parameter int unsigned MAX_FIELD_STARS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  in_t    head;
  q_ctl_t q_ctl;
  logic   not_empty;
  logic   pop;

  qifm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .head_o      (head),
    .pop_i       (pop),
    .not_empty_o (not_empty)
  );

  always_comb begin
    q_ctl.not_empty = not_empty;
  end

  qifm_back #(
    .MAX_FIELD_STARS (MAX_FIELD_STARS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .q_i            (q_ctl),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: sv/qifm_checker.sv
// qifm_checker: port level assertions for quad_in_field_membership, with bind
// depends on qifm_pkg
module qifm_checker import qifm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic result_valid_o,
  input out_t result_o
);

  busy_needs_transaction: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !$past(busy) && !$past(start) |-> !busy
  ) else $error("busy rose without an accepted transaction");

  busy_rise_after_start: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)
  ) else $error("busy rose without start");

  result_known: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(result_o)
  ) else $error("result has unknown bits");

  strobe_known: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(result_valid_o) && !$isunknown(busy)
  ) else $error("control output unknown");

  item_known: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> !$isunknown(item_i)
  ) else $error("accepted transaction has unknown bits");

endmodule

bind quad_in_field_membership qifm_checker u_qifm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

FILE: tb/sv/tb_quad_in_field_membership.sv
// tb_quad_in_field_membership: self-checking testbench for the quad in field membership block
// a directed table and random command sequences are checked against typed rows or a field model
// depends on qifm_pkg and quad_in_field_membership
module tb_quad_in_field_membership;
  import qifm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_DEPTH = 256;
  localparam int unsigned RAND_ITEMS  = 1200;
  localparam int unsigned DRAIN       = 2 * FIELD_DEPTH + 16;
  localparam int unsigned LIMIT       = 2_000_000;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [31:0] ID_MIN      = 32'h8000_0000;
  localparam logic [31:0] ID_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] ID_NEG1     = 32'hFFFF_FFFF;
  localparam logic [31:0] FILL_BASE   = 32'h1000_0000;

  typedef struct {
    in_t         cmd;
    int unsigned reps;
    bit          typed;
    out_t        want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic result_valid_o;
  out_t result_o;

  quad_in_field_membership #(
    .MAX_FIELD_STARS(FIELD_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // field model
  logic [31:0] fld_ids [FIELD_DEPTH];
  int unsigned fld_count = 0;
  bit          fld_ovf = 1'b0;
  logic [31:0] last_drop = '0;

  out_t        expected_q [$];
  dir_row_t    dir_tab [$];
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned rand_base = 0;
  int unsigned idle_pct = 36;
  int unsigned n_results = 0;
  int unsigned n_hits = 0;
  int unsigned n_ovf = 0;
  int unsigned cyc = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $realtime, cyc,
               expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_t mk_cmd(logic [1:0] op, logic [31:0] id, logic [31:0] qidx,
                                 logic [31:0] q0, logic [31:0] q1, logic [31:0] q2,
                                 logic [31:0] q3);
    in_t c;
    c.operation   = op;
    c.star_id     = id;
    c.quad_index  = qidx;
    c.quad_star_0 = q0;
    c.quad_star_1 = q1;
    c.quad_star_2 = q2;
    c.quad_star_3 = q3;
    return c;
  endfunction

  function automatic in_t rand_cmd(logic [1:0] op);
    return mk_cmd(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic bit field_step(input in_t c, output out_t res);
    bit [3:0] hit;
    logic [31:0] q [4];
    hit = '0;
    res = '0;
    q[0] = c.quad_star_0;
    q[1] = c.quad_star_1;
    q[2] = c.quad_star_2;
    q[3] = c.quad_star_3;
    case (c.operation)
      OP_CLEAR: begin
        fld_count = 0;
        fld_ovf   = 1'b0;
        return 1'b0;
      end
      OP_ADD: begin
        if (fld_count < FIELD_DEPTH) begin
          fld_ids[fld_count] = c.star_id;
          fld_count++;
        end else begin
          fld_ovf = 1'b1;
        end
        return 1'b0;
      end
      OP_TEST: begin
        for (int unsigned k = 0; k < fld_count; k++) begin
          for (int j = 0; j < 4; j++) begin
            if (fld_ids[k] == q[j]) hit[j] = 1'b1;
          end
        end
        res.result_quad_index = c.quad_index;
        res.all_present       = &hit;
        res.overflowed        = fld_ovf;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] pick_id();
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s < 8 && fld_count > 0) return fld_ids[$urandom_range(0, fld_count - 1)];
    if (s == 8) return last_drop;
    return $urandom;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input in_t c, input bit typed, input out_t want);
    out_t pred;
    int unsigned rel;
    rel = n_sent - rand_base;
    idle_pct = (rel < RAND_ITEMS / 3) ? 36 : (rel < 2 * RAND_ITEMS / 3) ? 70 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (c.operation == OP_ADD && fld_count == FIELD_DEPTH) last_drop = c.star_id;
    if (field_step(c, pred)) expected_q.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (result_o.all_present) n_hits++;
      if (result_o.overflowed) n_ovf++;
      if (expected_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result: expected none actual %h", $realtime, result_o);
      end else begin
        want = expected_q.pop_front();
        if (result_o.result_quad_index !== want.result_quad_index) begin
          err_cnt++;
          $display("%0t result_quad_index: expected %h actual %h", $realtime,
                   want.result_quad_index, result_o.result_quad_index);
        end
        if (result_o.all_present !== want.all_present) begin
          err_cnt++;
          $display("%0t all_present (quad %h): expected %b actual %b", $realtime,
                   want.result_quad_index, want.all_present, result_o.all_present);
        end
        if (result_o.overflowed !== want.overflowed) begin
          err_cnt++;
          $display("%0t overflowed (quad %h): expected %b actual %b", $realtime,
                   want.result_quad_index, want.overflowed, result_o.overflowed);
        end
      end
    end
  end

  initial begin
    in_t         c;
    out_t        none;
    dir_row_t    r;
    int unsigned n;
    int unsigned t;
    int unsigned sel;
    bit          pool;
    none   = '0;
    start  <= 1'b0;
    item_i <= '0;
    rst_ni <= 1'b0;

    // empty after reset, extremes, repeats, unused code, overflow and its clear
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, ID_NEG1, ID_MIN, ID_MAX, 0, ID_NEG1), 1, 1,
                        {ID_NEG1, 1'b0, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_UNUSED, 5, 32'h1234_5678, 5, 5, 5, 5), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_ADD, ID_MIN, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_ADD, ID_MAX, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_ADD, 0, ID_NEG1, ID_NEG1, ID_NEG1, ID_NEG1, ID_NEG1), 1, 0,
                        none});
    dir_tab.push_back('{mk_cmd(OP_ADD, ID_NEG1, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 0, ID_MIN, ID_MAX, 0, ID_NEG1), 1, 1,
                        {32'd0, 1'b1, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 1, ID_MAX, ID_MAX, ID_MAX, ID_MAX), 1, 1,
                        {32'd1, 1'b1, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 2, ID_MIN, ID_MAX, 0, 5), 1, 1,
                        {32'd2, 1'b0, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 3, 5, 5, 5, 5), 1, 1, {32'd3, 1'b0, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_CLEAR, ID_NEG1, ID_NEG1, ID_NEG1, ID_NEG1, ID_NEG1, ID_NEG1),
                        1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 4, 0, 0, 0, 0), 1, 1, {32'd4, 1'b0, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_ADD, FILL_BASE, 0, 0, 0, 0, 0), FIELD_DEPTH + 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 5, FILL_BASE, FILL_BASE + 255, FILL_BASE + 128,
                        FILL_BASE), 1, 1, {32'd5, 1'b1, 1'b1}});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 6, FILL_BASE, FILL_BASE + 256, FILL_BASE,
                        FILL_BASE), 1, 1, {32'd6, 1'b0, 1'b1}});
    dir_tab.push_back('{mk_cmd(OP_ADD, 0, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 7, 0, FILL_BASE, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 8, FILL_BASE, FILL_BASE, FILL_BASE, FILL_BASE), 1, 1,
                        {32'd8, 1'b0, 1'b0}});
    dir_tab.push_back('{mk_cmd(OP_ADD, 32'h5A5A_5A5A, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_ADD, 32'hA5A5_A5A5, 0, 0, 0, 0, 0), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                        32'hA5A5_A5A5, 32'h5A5A_5A5A), 1, 0, none});
    dir_tab.push_back('{mk_cmd(OP_TEST, 0, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                        32'h5A5A_5A5B, 32'h5A5A_5A5A), 1, 0, none});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      for (int unsigned k = 0; k < r.reps; k++) begin
        c = r.cmd;
        c.star_id = r.cmd.star_id + k;
        send_item(c, r.typed, r.want);
      end
    end

    rand_base = n_sent;
    while (n_sent - rand_base < RAND_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 4) != 0) send_item(rand_cmd(OP_CLEAR), 1'b0, none);
        sel  = $urandom_range(0, 99);
        n    = (sel < 70) ? $urandom_range(1, 12) :
               (sel < 90) ? $urandom_range(13, 64) : $urandom_range(250, 270);
        pool = ($urandom_range(0, 3) == 0);
        for (int unsigned k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) send_item(rand_cmd(OP_UNUSED), 1'b0, none);
          c = rand_cmd(OP_ADD);
          if (pool) c.star_id = $urandom_range(0, 15) - 8;
          send_item(c, 1'b0, none);
        end
        t = $urandom_range(1, 6);
        for (int unsigned k = 0; k < t; k++) begin
          c = rand_cmd(OP_TEST);
          c.quad_star_0 = pick_id();
          c.quad_star_1 = pick_id();
          c.quad_star_2 = pick_id();
          c.quad_star_3 = pick_id();
          send_item(c, 1'b0, none);
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int unsigned k = 0; k < n; k++) begin
          c = rand_cmd(2'($urandom_range(0, 3)));
          if (c.operation == OP_TEST && $urandom_range(0, 1) == 0) begin
            c.quad_star_0 = pick_id();
            c.quad_star_2 = pick_id();
          end
          send_item(c, 1'b0, none);
        end
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("covered %0d transactions (%0d directed), %0d quad test results checked",
             n_sent, rand_base, n_results);
    $display("%0d tests found all four stars, %0d reported an overflowed field",
             n_hits, n_ovf);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
